// ===== hw/rtl/owm_pkg.sv =====
package owm_pkg;

    // timer width default
    localparam int TIMER_BITS_DEF = 10;

    localparam int CFG_BITS  = 10;
    localparam int NUM_REGS  = 8;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;
    localparam int BYTE_BITS = 8;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_TAIL = 3'd1;
    localparam logic [2:0] REG_ONE_LOW       = 3'd2;
    localparam logic [2:0] REG_ONE_REC       = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW      = 3'd4;
    localparam logic [2:0] REG_ZERO_REC      = 3'd5;
    localparam logic [2:0] REG_READ_LOW      = 3'd6;
    localparam logic [2:0] REG_READ_REC      = 3'd7;

    // register reset values, in ticks
    localparam logic [CFG_BITS-1:0] DEF_RESET_LOW     = 10'd500;
    localparam logic [CFG_BITS-1:0] DEF_PRESENCE_TAIL = 10'd300;
    localparam logic [CFG_BITS-1:0] DEF_ONE_LOW       = 10'd8;
    localparam logic [CFG_BITS-1:0] DEF_ONE_REC       = 10'd80;
    localparam logic [CFG_BITS-1:0] DEF_ZERO_LOW      = 10'd90;
    localparam logic [CFG_BITS-1:0] DEF_ZERO_REC      = 10'd5;
    localparam logic [CFG_BITS-1:0] DEF_READ_LOW      = 10'd2;
    localparam logic [CFG_BITS-1:0] DEF_READ_REC      = 10'd70;

    // command codes
    localparam logic [1:0] FUNC_NONE  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    typedef struct packed {
        logic [CFG_BITS-1:0] reset_low_time;
        logic [CFG_BITS-1:0] presence_tail_time;
        logic [CFG_BITS-1:0] one_low_time;
        logic [CFG_BITS-1:0] one_recovery_time;
        logic [CFG_BITS-1:0] zero_low_time;
        logic [CFG_BITS-1:0] zero_recovery_time;
        logic [CFG_BITS-1:0] read_low_time;
        logic [CFG_BITS-1:0] read_recovery_time;
    } t_cfg;

endpackage

// ===== hw/rtl/one_wire_master_slot_engine.sv =====
// path: the slot step lies between the input register and the result register,
// which holds the result word of each tick word; one tick word per cycle is taken
// while the receiver does not stall the result register
// reset: synchronous, active low; timing registers return to their defaults,
// the slot engine goes idle and the held read byte clears
module one_wire_master_slot_engine
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // apb-style configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,

    // tick word in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [BYTE_BITS-1:0] i_write_data,
    input  logic                 i_bus_level,

    // result word out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_drive_low,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [BYTE_BITS-1:0] o_read_data
);

    t_cfg w_cfg;

    // input register
    logic                 r_in_vld;
    logic [1:0]           r_func;
    logic [BYTE_BITS-1:0] r_wdata;
    logic                 r_bus;

    // result register
    logic                 r_out_vld;
    logic                 r_drive;
    logic                 r_busy;
    logic                 r_done;
    logic [BYTE_BITS-1:0] r_rdata;

    logic                 w_accept;
    logic                 w_adv;
    logic                 w_drive;
    logic                 w_busy;
    logic                 w_done;
    logic [BYTE_BITS-1:0] w_rdata;

    owm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the held word steps the engine once the result register has room
    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    // input side only stalls when both registers are full and output is blocked
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    owm_slot #(
        .TIMER_BITS (TIMER_BITS)
    ) u_slot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_cfg        (w_cfg),
        .i_func       (r_func),
        .i_write_data (r_wdata),
        .i_bus_level  (r_bus),
        .o_drive_low  (w_drive),
        .o_busy_res   (w_busy),
        .o_done_res   (w_done),
        .o_read_data  (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_wdata <= i_write_data;
            r_bus   <= i_bus_level;
        end
        if (w_adv) begin
            r_drive <= w_drive;
            r_busy  <= w_busy;
            r_done  <= w_done;
            r_rdata <= w_rdata;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive_low = r_drive;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_read_data = r_rdata;

endmodule

// ===== hw/rtl/owm_regs.sv =====
module owm_regs
    import owm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    logic [CFG_BITS-1:0] r_regs [NUM_REGS];
    logic [2:0]          w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = DATA_BITS'(r_regs[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_RESET_LOW]     <= DEF_RESET_LOW;
            r_regs[REG_PRESENCE_TAIL] <= DEF_PRESENCE_TAIL;
            r_regs[REG_ONE_LOW]       <= DEF_ONE_LOW;
            r_regs[REG_ONE_REC]       <= DEF_ONE_REC;
            r_regs[REG_ZERO_LOW]      <= DEF_ZERO_LOW;
            r_regs[REG_ZERO_REC]      <= DEF_ZERO_REC;
            r_regs[REG_READ_LOW]      <= DEF_READ_LOW;
            r_regs[REG_READ_REC]      <= DEF_READ_REC;
        end else if (psel && penable && pwrite && pready) begin
            r_regs[w_idx] <= pwdata[CFG_BITS-1:0];
        end
    end

    assign o_cfg.reset_low_time     = r_regs[REG_RESET_LOW];
    assign o_cfg.presence_tail_time = r_regs[REG_PRESENCE_TAIL];
    assign o_cfg.one_low_time       = r_regs[REG_ONE_LOW];
    assign o_cfg.one_recovery_time  = r_regs[REG_ONE_REC];
    assign o_cfg.zero_low_time      = r_regs[REG_ZERO_LOW];
    assign o_cfg.zero_recovery_time = r_regs[REG_ZERO_REC];
    assign o_cfg.read_low_time      = r_regs[REG_READ_LOW];
    assign o_cfg.read_recovery_time = r_regs[REG_READ_REC];

endmodule

// ===== hw/rtl/owm_slot.sv =====
module owm_slot
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_cfg                 i_cfg,
    input  logic [1:0]           i_func,
    input  logic [BYTE_BITS-1:0] i_write_data,
    input  logic                 i_bus_level,
    output logic                 o_drive_low,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [BYTE_BITS-1:0] o_read_data
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_REL, PH_PRES_WAIT_LOW, PH_PRES_WAIT_HIGH,
        PH_PRES_TAIL, PH_WR_LOW, PH_WR_REC, PH_RD_LOW, PH_RD_REL,
        PH_RD_SAMPLE, PH_RD_REC
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_count, n_count;
    logic [BYTE_BITS-1:0]  r_shift, n_shift;
    logic [3:0]            r_bits,  n_bits;
    logic [BYTE_BITS-1:0]  r_held,  n_held;

    logic [TIMER_BITS-1:0] w_count_dec;
    logic                  w_count_end;
    logic [3:0]            w_bits_inc;

    // truncate to timer width, zero counts as one tick
    function automatic logic [TIMER_BITS-1:0] f_load(input logic [CFG_BITS-1:0] v);
        logic [TIMER_BITS-1:0] t;
        t = TIMER_BITS'(v);
        return (t == '0) ? TIMER_BITS'(1) : t;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_held      = r_held;
        o_drive_low = 1'b0;
        o_done_res  = 1'b0;

        // command start shares its first tick with the phase logic below
        if (r_phase == PH_IDLE && i_func != FUNC_NONE) begin
            n_bits = '0;
            case (i_func)
                FUNC_RESET: begin
                    n_phase = PH_RST_LOW;
                    n_count = f_load(i_cfg.reset_low_time);
                end
                FUNC_WRITE: begin
                    n_shift = i_write_data;
                    n_phase = PH_WR_LOW;
                    n_count = i_write_data[0] ? f_load(i_cfg.one_low_time)
                                              : f_load(i_cfg.zero_low_time);
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                    n_count = f_load(i_cfg.read_low_time);
                end
            endcase
        end

        w_count_dec = (n_count != '0) ? n_count - TIMER_BITS'(1) : n_count;
        w_count_end = (w_count_dec == '0);
        w_bits_inc  = n_bits + 4'd1;

        unique case (n_phase)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                o_drive_low = 1'b1;
                n_count     = w_count_dec;
                if (w_count_end) begin
                    n_phase = PH_RST_REL;
                    n_count = TIMER_BITS'(1);
                end
            end
            PH_RST_REL: begin
                n_count = w_count_dec;
                if (w_count_end) n_phase = PH_PRES_WAIT_LOW;
            end
            PH_PRES_WAIT_LOW: begin
                if (!i_bus_level) n_phase = PH_PRES_WAIT_HIGH;
            end
            PH_PRES_WAIT_HIGH: begin
                if (i_bus_level) begin
                    n_phase = PH_PRES_TAIL;
                    n_count = f_load(i_cfg.presence_tail_time);
                end
            end
            PH_PRES_TAIL: begin
                n_count = w_count_dec;
                if (w_count_end) begin
                    n_phase    = PH_IDLE;
                    o_done_res = 1'b1;
                end
            end
            PH_WR_LOW: begin
                o_drive_low = 1'b1;
                n_count     = w_count_dec;
                if (w_count_end) begin
                    n_phase = PH_WR_REC;
                    n_count = n_shift[0] ? f_load(i_cfg.one_recovery_time)
                                         : f_load(i_cfg.zero_recovery_time);
                end
            end
            PH_WR_REC: begin
                n_count = w_count_dec;
                if (w_count_end) begin
                    n_shift = n_shift >> 1;
                    n_bits  = w_bits_inc;
                    if (w_bits_inc >= 4'(BYTE_BITS)) begin
                        n_phase    = PH_IDLE;
                        o_done_res = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                        n_count = n_shift[0] ? f_load(i_cfg.one_low_time)
                                             : f_load(i_cfg.zero_low_time);
                    end
                end
            end
            PH_RD_LOW: begin
                o_drive_low = 1'b1;
                n_count     = w_count_dec;
                if (w_count_end) begin
                    n_phase = PH_RD_REL;
                    n_count = TIMER_BITS'(1);
                end
            end
            PH_RD_REL: begin
                n_count = w_count_dec;
                if (w_count_end) n_phase = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                n_shift = {i_bus_level, n_shift[BYTE_BITS-1:1]};
                n_phase = PH_RD_REC;
                n_count = f_load(i_cfg.read_recovery_time);
            end
            PH_RD_REC: begin
                n_count = w_count_dec;
                if (w_count_end) begin
                    n_bits = w_bits_inc;
                    if (w_bits_inc >= 4'(BYTE_BITS)) begin
                        n_held     = n_shift;
                        n_phase    = PH_IDLE;
                        o_done_res = 1'b1;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_count = f_load(i_cfg.read_low_time);
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_busy_res  = (n_phase != PH_IDLE);
        o_read_data = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_held  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_held  <= n_held;
        end
    end

endmodule

// ===== bench/owm_slot_monitor.sv =====
// watches the tick and result channels and the config port, predicts every
// result word of the slot engine and compares it field by field
module owm_slot_monitor
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    input  logic [DATA_BITS-1:0] prdata,
    input  logic                 pready,

    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_func,
    input  logic [BYTE_BITS-1:0] i_write_data,
    input  logic                 i_bus_level,

    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_drive_low,
    input  logic                 i_busy_res,
    input  logic                 i_done_res,
    input  logic [BYTE_BITS-1:0] i_read_data,

    output int                   o_fail_count,
    output int                   o_pending,
    output logic                 o_engine_idle
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST_LOW,
        ST_RST_REL,
        ST_PRES_LOW,
        ST_PRES_HIGH,
        ST_PRES_TAIL,
        ST_WR_LOW,
        ST_WR_REC,
        ST_RD_LOW,
        ST_RD_REL,
        ST_RD_SAMPLE,
        ST_RD_REC
    } engine_phase_t;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy;
        logic                 done;
        logic [BYTE_BITS-1:0] read_data;
    } slot_result_t;

    // shadow of the timing registers and of the slot engine
    logic [CFG_BITS-1:0]  timing [NUM_REGS];
    engine_phase_t        phase = ST_IDLE;
    logic [CFG_BITS-1:0]  countdown;
    logic [BYTE_BITS-1:0] shreg;
    logic [3:0]           bits_done;
    logic [BYTE_BITS-1:0] held_byte;

    slot_result_t results_due [$];
    slot_result_t want;
    slot_result_t got;
    int           failures = 0;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_engine_idle = 1'b1;
    end

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        failures++;
        if (failures <= 40)
            $display("mismatch: %s wanted %0h got %0h at %0t", what, want_v, got_v, $time);
    endtask

    task automatic reset_engine_model();
        timing[REG_RESET_LOW]     = DEF_RESET_LOW;
        timing[REG_PRESENCE_TAIL] = DEF_PRESENCE_TAIL;
        timing[REG_ONE_LOW]       = DEF_ONE_LOW;
        timing[REG_ONE_REC]       = DEF_ONE_REC;
        timing[REG_ZERO_LOW]      = DEF_ZERO_LOW;
        timing[REG_ZERO_REC]      = DEF_ZERO_REC;
        timing[REG_READ_LOW]      = DEF_READ_LOW;
        timing[REG_READ_REC]      = DEF_READ_REC;
        phase     = ST_IDLE;
        countdown = '0;
        shreg     = '0;
        bits_done = '0;
        held_byte = '0;
    endtask

    // truncated to the timer width, a zero time still lasts one tick
    function automatic logic [CFG_BITS-1:0] timer_load(input logic [2:0] idx);
        logic [CFG_BITS-1:0] v;
        v = timing[idx] & CFG_BITS'((1 << TIMER_BITS) - 1);
        return (v == '0) ? CFG_BITS'(1) : v;
    endfunction

    function automatic logic [CFG_BITS-1:0] step_down(input logic [CFG_BITS-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    // one microsecond tick of the engine
    function automatic slot_result_t step_engine(input logic [1:0] f,
                                                 input logic [BYTE_BITS-1:0] wd,
                                                 input logic bus);
        slot_result_t r;
        r = '0;
        if (phase == ST_IDLE && f != FUNC_NONE) begin
            bits_done = '0;
            case (f)
                FUNC_RESET: begin
                    phase     = ST_RST_LOW;
                    countdown = timer_load(REG_RESET_LOW);
                end
                FUNC_WRITE: begin
                    shreg     = wd;
                    phase     = ST_WR_LOW;
                    countdown = timer_load(shreg[0] ? REG_ONE_LOW : REG_ZERO_LOW);
                end
                default: begin
                    shreg     = '0;
                    phase     = ST_RD_LOW;
                    countdown = timer_load(REG_READ_LOW);
                end
            endcase
        end

        case (phase)
            ST_IDLE: ;
            ST_RST_LOW: begin
                r.drive_low = 1'b1;
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    phase     = ST_RST_REL;
                    countdown = CFG_BITS'(1);
                end
            end
            ST_RST_REL: begin
                countdown = step_down(countdown);
                if (countdown == '0)
                    phase = ST_PRES_LOW;
            end
            ST_PRES_LOW: begin
                if (!bus)
                    phase = ST_PRES_HIGH;
            end
            ST_PRES_HIGH: begin
                if (bus) begin
                    phase     = ST_PRES_TAIL;
                    countdown = timer_load(REG_PRESENCE_TAIL);
                end
            end
            ST_PRES_TAIL: begin
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    phase  = ST_IDLE;
                    r.done = 1'b1;
                end
            end
            ST_WR_LOW: begin
                r.drive_low = 1'b1;
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    phase     = ST_WR_REC;
                    countdown = timer_load(shreg[0] ? REG_ONE_REC : REG_ZERO_REC);
                end
            end
            ST_WR_REC: begin
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    shreg     = shreg >> 1;
                    bits_done = bits_done + 1'b1;
                    if (bits_done >= 4'd8) begin
                        phase  = ST_IDLE;
                        r.done = 1'b1;
                    end else begin
                        phase     = ST_WR_LOW;
                        countdown = timer_load(shreg[0] ? REG_ONE_LOW : REG_ZERO_LOW);
                    end
                end
            end
            ST_RD_LOW: begin
                r.drive_low = 1'b1;
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    phase     = ST_RD_REL;
                    countdown = CFG_BITS'(1);
                end
            end
            ST_RD_REL: begin
                countdown = step_down(countdown);
                if (countdown == '0)
                    phase = ST_RD_SAMPLE;
            end
            ST_RD_SAMPLE: begin
                shreg     = {bus, shreg[BYTE_BITS-1:1]};
                phase     = ST_RD_REC;
                countdown = timer_load(REG_READ_REC);
            end
            ST_RD_REC: begin
                countdown = step_down(countdown);
                if (countdown == '0) begin
                    bits_done = bits_done + 1'b1;
                    if (bits_done >= 4'd8) begin
                        held_byte = shreg;
                        phase     = ST_IDLE;
                        r.done    = 1'b1;
                    end else begin
                        phase     = ST_RD_LOW;
                        countdown = timer_load(REG_READ_LOW);
                    end
                end
            end
            default: phase = ST_IDLE;
        endcase

        r.busy      = (phase != ST_IDLE);
        r.read_data = held_byte;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_engine_model();
            results_due.delete();
        end else begin
            // config port, writes land in the shadow, reads are checked
            if (psel && penable && pready) begin
                if (pwrite)
                    timing[paddr[ADDR_BITS-1:2]] = pwdata[CFG_BITS-1:0];
                else if (prdata !== DATA_BITS'(timing[paddr[ADDR_BITS-1:2]]))
                    report_mismatch("register read", timing[paddr[ADDR_BITS-1:2]], prdata);
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{i_drive_low, i_busy_res, i_done_res, i_read_data};
                if (results_due.size() == 0) begin
                    report_mismatch("result word with none due", 0, 1);
                end else begin
                    want = results_due.pop_front();
                    if (got.drive_low !== want.drive_low)
                        report_mismatch("drive_low", want.drive_low, got.drive_low);
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", want.busy, got.busy);
                    if (got.done !== want.done)
                        report_mismatch("done_res", want.done, got.done);
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, got.read_data);
                end
            end

            if (i_in_valid && !i_in_stall)
                results_due.push_back(step_engine(i_func, i_write_data, i_bus_level));
        end
        o_fail_count  <= failures;
        o_pending     <= results_due.size();
        o_engine_idle <= (phase == ST_IDLE);
    end

endmodule

// ===== bench/one_wire_master_slot_engine_tb.sv =====
// top of the bench: makes the tick words, the config traffic and the
// receiver stalls, the monitor beside the block does all the checking
module one_wire_master_slot_engine_tb;
    import owm_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT  = 5000;
    localparam int SMALL_PHASES = 5;
    localparam int SMALL_TICKS  = 110;
    localparam int WIDE_TICKS   = 150;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_func       = FUNC_NONE;
    logic [BYTE_BITS-1:0] i_write_data = '0;
    logic                 i_bus_level  = 1'b1;

    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic                 o_drive_low;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [BYTE_BITS-1:0] o_read_data;

    int                   fail_count;
    int                   pending;
    logic                 engine_idle;

    // sender burst and receiver pattern state
    int                   burst_left    = 0;
    int                   quiet_cycles  = 0;
    int                   results_taken = 0;
    int                   hold_left     = 0;
    bit                   hold_used     = 1'b0;
    int                   pattern_mode  = 0;
    int                   pattern_left  = 0;

    always #5 i_clk = ~i_clk;

    one_wire_master_slot_engine uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_write_data (i_write_data),
        .i_bus_level  (i_bus_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_drive_low  (o_drive_low),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data)
    );

    owm_slot_monitor slot_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_write_data  (i_write_data),
        .i_bus_level   (i_bus_level),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_drive_low   (o_drive_low),
        .i_busy_res    (o_busy_res),
        .i_done_res    (o_done_res),
        .i_read_data   (o_read_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_engine_idle (engine_idle)
    );

    // offer one tick word and hold it until taken; the stall seen right
    // after the edge is the pre-edge value, so acceptance is race free
    task automatic send_word(input logic [1:0] f, input logic [BYTE_BITS-1:0] wd,
                             input logic bl);
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_write_data <= wd;
        i_bus_level  <= bl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // gap between bursts, then pick the next burst length
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // half the time no command, the rest spread over the three commands
    function automatic logic [1:0] random_func();
        case ($urandom_range(0, 5))
            3:       return FUNC_RESET;
            4:       return FUNC_WRITE;
            5:       return FUNC_READ;
            default: return FUNC_NONE;
        endcase
    endfunction

    // apb write: setup cycle, access cycle, then the bus goes idle
    task automatic reg_write(input int idx, input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // apb read, the monitor checks prdata at the access edge
    task automatic reg_read(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BITS'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_timings();
        for (int i = 0; i < NUM_REGS; i++)
            reg_read(i);
    endtask

    // upper data bits carry junk, only the low ten bits are stored
    task automatic load_timings(input logic [CFG_BITS-1:0] t [NUM_REGS]);
        logic [DATA_BITS-1:0] data;
        for (int i = 0; i < NUM_REGS; i++) begin
            data = $urandom;
            data[CFG_BITS-1:0] = t[i];
            reg_write(i, data);
        end
        read_timings();
    endtask

    // feed empty ticks until the engine has finished its command, then
    // drain every result word so the block is idle for config writes
    task automatic settle_block();
        do begin
            send_word(FUNC_NONE, BYTE_BITS'($urandom), 1'($urandom));
        end while (!engine_idle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_command(input logic [1:0] f, input logic [BYTE_BITS-1:0] wd);
        send_word(f, wd, 1'($urandom));
        do begin
            send_word(FUNC_NONE, BYTE_BITS'($urandom), 1'($urandom));
        end while (!engine_idle);
    endtask

    // receiver: stall pattern of its own, plus one long hold-off once a
    // few hundred words are through so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_used && results_taken >= HOLD_AFTER) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(20, 200);
                end else begin
                    pattern_left--;
                end
                case (pattern_mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // watchdog on any handshake, tick word, result word or config access
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                     (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_BITS-1:0] t [NUM_REGS];
        int ticks;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the timing registers
        read_timings();

        // zero times everywhere, each one must still last a single tick
        for (int i = 0; i < NUM_REGS; i++)
            t[i] = '0;
        load_timings(t);

        // no command while idle, then a reset with a silent bus first,
        // presence low for two ticks, and commands offered while busy
        send_word(FUNC_NONE,  8'hFF, 1'b0);
        send_word(FUNC_RESET, 8'h00, 1'b1);
        send_word(FUNC_WRITE, 8'hFF, 1'b1);
        send_word(FUNC_READ,  8'h00, 1'b1);
        send_word(FUNC_WRITE, 8'h5A, 1'b0);
        send_word(FUNC_NONE,  8'h00, 1'b0);
        send_word(FUNC_RESET, 8'hFF, 1'b1);
        send_word(FUNC_WRITE, 8'hA5, 1'b1);

        // byte extremes and one read; read_data must hold over writes
        run_command(FUNC_WRITE, 8'h00);
        run_command(FUNC_WRITE, 8'hFF);
        run_command(FUNC_READ,  8'h00);
        run_command(FUNC_WRITE, 8'h81);
        settle_block();

        // random phases: longer times first, then the shortest, then
        // small random times so most commands complete quickly
        for (int ph = 0; ph < SMALL_PHASES + 2; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (ph == 0)
                    t[i] = CFG_BITS'($urandom_range(10, 20));
                else if (ph == 1)
                    t[i] = CFG_BITS'(1);
                else if ($urandom_range(0, 9) == 0)
                    t[i] = CFG_BITS'($urandom_range(0, 60));
                else
                    t[i] = CFG_BITS'($urandom_range(0, 5));
            end
            load_timings(t);
            ticks = (ph == 0) ? WIDE_TICKS : SMALL_TICKS;
            repeat (ticks)
                send_word(random_func(), BYTE_BITS'($urandom), 1'($urandom));
            settle_block();
        end

        // last words are in, allow the pipeline to show any stray word
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
